@@ rtl/rsrt_pkg.sv @@
// Package for the ranged symbol remap table core.
// Holds widths, opcodes, status and class codes and the item/result structs.
// No dependencies.
package rsrt_pkg;

	localparam int MAX_RANGES = 8;
	localparam int TABLE_SIZE = 256;
	localparam int TAB_AW     = 8;
	localparam int LEN_W      = 9;
	localparam int RAW_W      = 12;
	localparam int RIDX_W     = 3;
	localparam int RCNT_W     = 4;
	localparam logic [7:0] UNDEF_CODE = 8'd255;
	localparam logic [LEN_W-1:0] TABLE_SIZE_L = LEN_W'(TABLE_SIZE);
	localparam logic [RCNT_W-1:0] RANGE_COUNT_RST = 4'd2;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_LOAD     = 3'd0,
		OP_SETLEN   = 3'd1,
		OP_FORWARD  = 3'd2,
		OP_REVERSE  = 3'd3,
		OP_INSERT   = 3'd4,
		OP_CLASSIFY = 3'd5,
		OP_NOP6     = 3'd6,
		OP_NOP7     = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MAPPED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_BAD_IDX  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_NOT_SEL = 2'd0,
		CLS_SEL     = 2'd1,
		CLS_BEYOND  = 2'd2
	} class_t;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		opcode_t             op;
		logic [7:0]          symbol;
		logic [7:0]          code_value;
		logic [RIDX_W-1:0]   range_index;
		logic [LEN_W-1:0]    range_length;
		logic [7:0]          selected_ranges;
		logic                idx_bad;
	} item_t;

	typedef struct packed {
		logic [7:0]       value;
		class_t           range_class;
		status_t          status;
		logic [LEN_W-1:0] total_symbols;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_SHIFT_RD,
		BK_SHIFT_WR,
		BK_FINISH,
		BK_CLEAR
	} back_state_t;

endpackage

@@ rtl/rsrt_front.sv @@
// Front part: accepts items and flags bad range indices against the effective range count.
// Depends on rsrt_pkg.
module rsrt_front import rsrt_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [7:0]        symbol,
	input  logic [7:0]        code_value,
	input  logic [RIDX_W-1:0] range_index,
	input  logic [LEN_W-1:0]  range_length,
	input  logic [7:0]        selected_ranges,
	input  logic [RCNT_W-1:0] eff_count,
	output logic              q_push,
	output item_t             q_item,
	input  logic              q_full
);

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;

	always_comb begin
		q_item.op              = opcode_t'(opcode);
		q_item.symbol          = symbol;
		q_item.code_value      = code_value;
		q_item.range_index     = range_index;
		q_item.range_length    = range_length;
		q_item.selected_ranges = selected_ranges;
		q_item.idx_bad         = {1'b0, range_index} >= eff_count;
	end

endmodule

@@ rtl/rsrt_queue.sv @@
// Short item queue between front and back parts.
// Depends on rsrt_pkg.
module rsrt_queue import rsrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	item_t slot_q [QUEUE_DEPTH];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full      = cnt_q == 2'(QUEUE_DEPTH);
	assign not_empty = cnt_q != 2'd0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("queue pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QUEUE_DEPTH))
		else $error("queue count overflow");

endmodule

@@ rtl/rsrt_back.sv @@
// Back part: table memories, range registers and the operation sequencer.
// Depends on rsrt_pkg.
module rsrt_back import rsrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RCNT_W-1:0] eff_count,
	input  logic              q_valid,
	input  item_t             q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output result_t           out_res
);

	logic [7:0] fwd_mem [TABLE_SIZE];
	logic [7:0] rev_mem [TABLE_SIZE];

	logic [LEN_W-1:0] len_q [MAX_RANGES];
	logic [RAW_W-1:0] raw_q [MAX_RANGES];   // unsaturated running sums of the lengths
	logic [LEN_W-1:0] ends_sat [MAX_RANGES];

	back_state_t state_q, state_d;
	item_t       cur_q;
	logic [TAB_AW:0] ptr_q;          // clear sweep and shift walk index
	logic [7:0]  fwd_rd_q, rev_rd_q;
	logic [7:0]  moved_q;
	logic        out_valid_q;
	result_t     res_q, res_d;
	logic        ins_ok_q, pend_inc_q;
	status_t     ins_st_q, ins_st;

	// lengths never go negative, so a saturated running sum is the clipped raw sum
	always_comb begin
		for (int r = 0; r < MAX_RANGES; r++)
			ends_sat[r] = (raw_q[r] > RAW_W'(TABLE_SIZE)) ? TABLE_SIZE_L : raw_q[r][LEN_W-1:0];
	end

	logic [LEN_W-1:0] total_now, pos_now;
	assign total_now = ends_sat[eff_count[RIDX_W-1:0] - RIDX_W'(1)];
	assign pos_now   = ends_sat[cur_q.range_index];

	// classify: search the first range whose end lies above the code
	logic [RCNT_W-1:0] cls_r;
	always_comb begin
		cls_r = RCNT_W'(MAX_RANGES);
		for (int r = MAX_RANGES - 1; r >= 0; r--) begin
			if (RCNT_W'(r) < eff_count && {1'b0, cur_q.symbol} < ends_sat[r]) cls_r = RCNT_W'(r);
		end
	end

	// insert checks in order: bad range, byte already mapped, table full
	always_comb begin
		priority if (cur_q.idx_bad) ins_st = ST_BAD_IDX;
		else if (fwd_rd_q != UNDEF_CODE) ins_st = ST_MAPPED;
		else if (total_now >= TABLE_SIZE_L) ins_st = ST_FULL;
		else ins_st = ST_OK;
	end

	logic rdy_out, fin;
	assign rdy_out = !out_valid_q || !out_stall;
	assign fin     = (state_q == BK_FINISH) && rdy_out;

	// length update of set length or accepted insert, as a delta on the raw sums
	logic             upd;
	logic [LEN_W-1:0] new_len;
	logic [RAW_W-1:0] delta, total_raw;
	logic [LEN_W-1:0] total_new;
	always_comb begin
		new_len = (cur_q.op == OP_SETLEN) ?
			((cur_q.range_length > TABLE_SIZE_L) ? TABLE_SIZE_L : cur_q.range_length) :
			len_q[cur_q.range_index] + LEN_W'(1);
		upd = (cur_q.op == OP_SETLEN && !cur_q.idx_bad) || ins_ok_q;
		delta = upd ? RAW_W'(new_len) - RAW_W'(len_q[cur_q.range_index]) : '0;
		total_raw = raw_q[eff_count[RIDX_W-1:0] - RIDX_W'(1)] + delta;
		total_new = (total_raw > RAW_W'(TABLE_SIZE)) ? TABLE_SIZE_L : total_raw[LEN_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR:    if (ptr_q == (TAB_AW+1)'(TABLE_SIZE - 1)) state_d = BK_IDLE;
			BK_IDLE:     if (q_valid) state_d = BK_READ;
			BK_READ: begin
				if (cur_q.op == OP_INSERT && ins_st == ST_OK) state_d = BK_SHIFT_RD;
				else state_d = BK_FINISH;
			end
			BK_SHIFT_RD: if (ptr_q > (TAB_AW+1)'(pos_now)) state_d = BK_SHIFT_WR;
				else state_d = BK_FINISH;
			BK_SHIFT_WR: state_d = BK_SHIFT_RD;
			BK_FINISH:   if (rdy_out) state_d = BK_IDLE;
			default:     state_d = BK_IDLE;
		endcase
	end

	assign q_pop = (state_q == BK_IDLE) && q_valid;

	// memory reads: one address per memory per cycle, registered
	logic [7:0] fwd_addr, rev_addr;
	always_comb begin
		fwd_addr = (state_q == BK_IDLE) ? q_head.symbol : cur_q.symbol;
		rev_addr = fwd_addr;
		if (state_q == BK_SHIFT_RD) rev_addr = ptr_q[TAB_AW-1:0] - 8'd1;
		if (state_q == BK_SHIFT_WR) fwd_addr = rev_rd_q;
	end

	logic       fwd_we, rev_we;
	logic [7:0] fwd_wa, fwd_wd, rev_wa, rev_wd;

	always_comb begin
		fwd_we = 1'b0; fwd_wa = cur_q.symbol; fwd_wd = cur_q.code_value;
		rev_we = 1'b0; rev_wa = cur_q.code_value; rev_wd = cur_q.symbol;
		unique case (state_q)
			BK_CLEAR: begin
				fwd_we = 1'b1; fwd_wa = ptr_q[TAB_AW-1:0]; fwd_wd = UNDEF_CODE;
				rev_we = 1'b1; rev_wa = ptr_q[TAB_AW-1:0]; rev_wd = UNDEF_CODE;
			end
			BK_READ: if (cur_q.op == OP_LOAD) begin
				fwd_we = 1'b1;
				rev_we = cur_q.code_value != UNDEF_CODE;
			end
			BK_SHIFT_RD: if (pend_inc_q) begin
				// commit increment of the byte moved in the previous step
				fwd_we = 1'b1; fwd_wa = moved_q; fwd_wd = fwd_rd_q + 8'd1;
			end
			BK_SHIFT_WR: begin
				rev_we = 1'b1; rev_wa = ptr_q[TAB_AW-1:0]; rev_wd = rev_rd_q;
			end
			BK_FINISH: if (ins_ok_q) begin
				fwd_we = 1'b1; fwd_wa = cur_q.symbol; fwd_wd = pos_now[7:0];
				rev_we = 1'b1; rev_wa = pos_now[7:0]; rev_wd = cur_q.symbol;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
		if (rev_we) rev_mem[rev_wa] <= rev_wd;
		fwd_rd_q <= fwd_mem[fwd_addr];
		rev_rd_q <= rev_mem[rev_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid) cur_q <= q_head;
		if (state_q == BK_SHIFT_WR) moved_q <= rev_rd_q;
		if (state_q == BK_READ) ins_st_q <= ins_st;
		if (fin) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			ins_ok_q    <= 1'b0;
			pend_inc_q  <= 1'b0;
			for (int r = 0; r < MAX_RANGES; r++) begin
				len_q[r] <= '0;
				raw_q[r] <= '0;
			end
		end else begin
			state_q     <= state_d;
			out_valid_q <= fin ? 1'b1 : (out_valid_q && out_stall);
			unique case (state_q)
				BK_CLEAR: ptr_q <= ptr_q + 1'b1;
				BK_READ: begin
					ins_ok_q   <= cur_q.op == OP_INSERT && ins_st == ST_OK;
					ptr_q      <= (TAB_AW+1)'(total_now);
					pend_inc_q <= 1'b0;
				end
				BK_SHIFT_WR: begin
					ptr_q      <= ptr_q - 1'b1;
					pend_inc_q <= 1'b1;
				end
				BK_FINISH: if (rdy_out && upd) begin
					len_q[cur_q.range_index] <= new_len;
					for (int r = 0; r < MAX_RANGES; r++) begin
						if (RIDX_W'(r) >= cur_q.range_index) raw_q[r] <= raw_q[r] + delta;
					end
				end
				default: ;
			endcase
		end
	end

	// result assembly; the total reflects the length update made in this step
	always_comb begin
		res_d.value         = UNDEF_CODE;
		res_d.range_class   = CLS_NOT_SEL;
		res_d.status        = ST_OK;
		res_d.total_symbols = total_new;
		unique case (cur_q.op)
			OP_FORWARD: res_d.value = fwd_rd_q;
			OP_REVERSE: res_d.value = rev_rd_q;
			OP_SETLEN:  if (cur_q.idx_bad) res_d.status = ST_BAD_IDX;
			OP_INSERT: begin
				res_d.status = ins_st_q;
				if (ins_ok_q) res_d.value = pos_now[7:0];
			end
			OP_CLASSIFY: begin
				if (cls_r >= eff_count) res_d.range_class = CLS_BEYOND;
				else if (cur_q.selected_ranges[cls_r[RIDX_W-1:0]] &&
					({2'b0, cur_q.symbol} + {1'b0, len_q[cls_r[RIDX_W-1:0]]}) >=
					{1'b0, ends_sat[cls_r[RIDX_W-1:0]]})
					res_d.range_class = CLS_SEL;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> state_q == BK_IDLE)
		else $error("pop outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SHIFT_WR |-> ptr_q > (TAB_AW+1)'(pos_now))
		else $error("shift walked below insert position");

endmodule

@@ rtl/ranged_symbol_remap_table_core.sv @@
// Top level of the ranged symbol remap table core.
// Depends on rsrt_pkg, rsrt_front, rsrt_queue and rsrt_back.
//
// Byte-to-code remap table with reverse table and up to eight code ranges. After reset the
// core sweeps both 256-entry tables to the undefined mark (input stalled once the queue is
// full) before the first item. Items are taken one at a time by the back sequencer: load,
// set length, forward, reverse, classify and a rejected insert pass through idle, memory
// read and finish; an accepted insert also walks a shift-read and shift-write step per
// moved code, since each moved code needs one reverse-table read and one forward-table
// update, and the last update is committed in a final shift-read step. The result is
// registered and appears the cycle after finish; while it waits, the back holds in finish.
// A two-entry queue lets the front keep accepting while the back works or its result waits.
module ranged_symbol_remap_table_core import rsrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [RCNT_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [7:0]        symbol,
	input  logic [7:0]        code_value,
	input  logic [RIDX_W-1:0] range_index,
	input  logic [LEN_W-1:0]  range_length,
	input  logic [7:0]        selected_ranges,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        value,
	output logic [1:0]        range_class,
	output logic [1:0]        status,
	output logic [LEN_W-1:0]  total_symbols
);

	logic [RCNT_W-1:0] range_count_q, eff_count;
	logic q_push, q_full, q_pop, q_ne;
	item_t q_item, q_head;
	result_t res;

	// Hold the register; writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) range_count_q <= RANGE_COUNT_RST;
		else if (cfg_valid) range_count_q <= cfg_data;
	end

	// Clamp zero up to one and large values down to the maximum.
	always_comb begin
		priority if (range_count_q == '0) eff_count = RCNT_W'(1);
		else if (range_count_q > RCNT_W'(MAX_RANGES)) eff_count = RCNT_W'(MAX_RANGES);
		else eff_count = range_count_q;
	end

	rsrt_front u_front (
		.in_valid, .in_stall, .opcode, .symbol, .code_value,
		.range_index, .range_length, .selected_ranges, .eff_count,
		.q_push, .q_item, .q_full
	);

	rsrt_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_item(q_item), .full(q_full),
		.pop(q_pop), .not_empty(q_ne), .head(q_head)
	);

	rsrt_back u_back (
		.clk, .arst_n, .eff_count, .q_valid(q_ne), .q_head, .q_pop,
		.out_valid, .out_stall, .out_res(res)
	);

	assign value         = res.value;
	assign range_class   = res.range_class;
	assign status        = res.status;
	assign total_symbols = res.total_symbols;

endmodule
